/* design/sitda_pkg.sv */
package sitda_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int CFG_W          = 5;
  localparam int CNT_W          = 5;
  localparam int CHAR_W         = 7;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CH_MINUS = 7'h2D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 7'h20;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_PUSH
  } front_state_t;

  typedef enum logic {
    B_IDLE,
    B_EMIT
  } back_state_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

/* design/sitda_front.sv */
module sitda_front
  import sitda_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [VALUE_BITS-1:0]  in_value,
  input  q_stat_t                       q_stat,
  output logic                          q_push,
  output logic [((VALUE_BITS*302)/1000+1)*4:0] q_wdata
);

  localparam int DIGITS = (VALUE_BITS * 302) / 1000 + 1;
  localparam int BCD_W  = DIGITS * 4;
  localparam int CNTB   = $clog2(VALUE_BITS);

  front_state_t            state_r, state_nxt;
  logic [VALUE_BITS-1:0]   bin_r, bin_nxt;
  logic [BCD_W-1:0]        bcd_r, bcd_nxt;
  logic                    neg_r, neg_nxt;
  logic [CNTB-1:0]         cnt_r, cnt_nxt;
  logic [VALUE_BITS-1:0]   raw;
  logic [VALUE_BITS-1:0]   mag;
  logic [BCD_W-1:0]        adj;
  logic                    accept;

  assign raw    = VALUE_BITS'(unsigned'(in_value));
  assign mag    = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
  assign accept = start && (state_r == F_IDLE);

  // shift-and-add-3: every digit that is 5 or more gets 3 before the shift
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd_r[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = bcd_r[i*4 +: 4] + 4'd3;
      end else begin
        adj[i*4 +: 4] = bcd_r[i*4 +: 4];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: begin
        if (start) state_nxt = F_CONV;
      end
      F_CONV: begin
        if (cnt_r == CNTB'(VALUE_BITS - 1)) state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (!q_stat.full) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    neg_nxt = neg_r;
    cnt_nxt = cnt_r;
    busy    = 1'b1;
    q_push  = 1'b0;
    unique case (state_r)
      F_IDLE: begin
        busy = 1'b0;
        if (accept) begin
          bin_nxt = mag;
          bcd_nxt = '0;
          neg_nxt = raw[VALUE_BITS-1];
          cnt_nxt = '0;
        end
      end
      F_CONV: begin
        bcd_nxt = {adj[BCD_W-2:0], bin_r[VALUE_BITS-1]};
        bin_nxt = {bin_r[VALUE_BITS-2:0], 1'b0};
        cnt_nxt = cnt_r + 1'b1;
      end
      F_PUSH: begin
        q_push = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

  assign q_wdata = {neg_r, bcd_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
    neg_r <= neg_nxt;
    cnt_r <= cnt_nxt;
  end

endmodule

/* design/sitda_fifo.sv */
module sitda_fifo
  import sitda_pkg::*;
#(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output q_stat_t          stat
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       count_r;
  logic             do_wr, do_rd;

  assign stat.full  = (count_r == 2'd2);
  assign stat.empty = (count_r == 2'd0);
  assign do_wr      = push && !stat.full;
  assign do_rd      = pop && !stat.empty;
  assign rdata      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (do_wr) wr_ptr_r <= ~wr_ptr_r;
      if (do_rd) rd_ptr_r <= ~rd_ptr_r;
      if (do_wr && !do_rd) begin
        count_r <= count_r + 2'd1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) mem_r[wr_ptr_r] <= wdata;
  end

endmodule

/* design/sitda_back.sv */
module sitda_back
  import sitda_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic [CFG_W-1:0]                     min_width,
  input  q_stat_t                              q_stat,
  input  logic [((VALUE_BITS*302)/1000+1)*4:0] q_rdata,
  output logic                                 q_pop,
  output logic                                 out_strobe,
  output logic [CHAR_W-1:0]                    out_character,
  output logic                                 out_last
);

  localparam int DIGITS = (VALUE_BITS * 302) / 1000 + 1;
  localparam int BCD_W  = DIGITS * 4;
  localparam int DIG_IW = (DIGITS > 1) ? $clog2(DIGITS) : 1;

  back_state_t        state_r, state_nxt;
  logic [BCD_W-1:0]   bcd_r;
  logic               neg_r;
  logic [CNT_W-1:0]   ndig_r;
  logic [CNT_W-1:0]   pos_r, pos_nxt;
  logic [CNT_W-1:0]   ndig_in;
  logic [CNT_W-1:0]   len_in;
  logic [CNT_W-1:0]   total_in;
  logic [3:0]         digit;
  logic               load;

  // count of significant digits, at least one so that zero prints as 0
  always_comb begin
    ndig_in = CNT_W'(1);
    for (int i = 1; i < DIGITS; i++) begin
      if (q_rdata[i*4 +: 4] != 4'd0) ndig_in = CNT_W'(i + 1);
    end
  end

  assign len_in   = ndig_in + CNT_W'(q_rdata[BCD_W]);
  assign total_in = (len_in > min_width) ? len_in : min_width;
  assign load     = (state_r == B_IDLE) && !q_stat.empty;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE: begin
        if (!q_stat.empty) state_nxt = B_EMIT;
      end
      B_EMIT: begin
        if (pos_r == '0) state_nxt = B_IDLE;
      end
      default: state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    pos_nxt = pos_r;
    if (load) begin
      pos_nxt = total_in - 1'b1;
    end else if (state_r == B_EMIT) begin
      pos_nxt = pos_r - 1'b1;
    end
  end

  // pos_r counts characters left after this one, so it is also the
  // position from the right of the character now shown
  assign digit = bcd_r[pos_r[DIG_IW-1:0]*4 +: 4];

  always_comb begin
    q_pop         = 1'b0;
    out_strobe    = 1'b0;
    out_last      = 1'b0;
    out_character = CH_SPACE;
    unique case (state_r)
      B_IDLE: begin
        q_pop = !q_stat.empty;
      end
      B_EMIT: begin
        out_strobe = 1'b1;
        out_last   = (pos_r == '0);
        if (pos_r < ndig_r) begin
          out_character = CH_ZERO + {3'b000, digit};
        end else if (neg_r && (pos_r == ndig_r)) begin
          out_character = CH_MINUS;
        end else begin
          out_character = CH_SPACE;
        end
      end
      default: q_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= B_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r <= pos_nxt;
    if (load) begin
      bcd_r  <= q_rdata[BCD_W-1:0];
      neg_r  <= q_rdata[BCD_W];
      ndig_r <= ndig_in;
    end
  end

endmodule

/* design/signed_int_to_decimal_ascii_unit.sv */
// Signed integer to decimal text converter.
// Input: pulse start with a two's complement in_value while busy is low; the
// word is taken at that clock edge. The block answers with a run of
// characters on out_character, one per cycle, each marked by out_strobe:
// leading spaces up to the field width, a minus sign for negative values,
// then the digits, most significant first. out_last marks the final one.
// cfg_we with cfg_wdata sets the minimum field width (0 to 31); write it
// only while no conversion is in flight.
// Operation: a binary-to-BCD front end shifts in one bit per cycle, and busy
// stays high until the converted word is pushed into the queue, which waits
// while the queue is full. A two-entry queue feeds the emitter, which picks
// up a word in its idle state and then emits max(text length, field width)
// characters. A new value can be taken while the emitter is still busy with
// the last one.
// The receiver cannot stall: every strobed character must be taken.
// Synchronous reset clears the field width to 0 and drops any word in flight.
module signed_int_to_decimal_ascii_unit
  import sitda_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [VALUE_BITS-1:0] in_value,
  output logic                         out_strobe,
  output logic [CHAR_W-1:0]            out_character,
  output logic                         out_last,
  input  logic                         cfg_we,
  input  logic [CFG_W-1:0]             cfg_wdata
);

  localparam int DIGITS = (VALUE_BITS * 302) / 1000 + 1;
  localparam int Q_W    = DIGITS * 4 + 1;

  logic [CFG_W-1:0] min_width_r;
  q_stat_t          q_stat;
  logic             q_push, q_pop;
  logic [Q_W-1:0]   q_wdata, q_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_width_r <= '0;
    end else if (cfg_we) begin
      min_width_r <= cfg_wdata;
    end
  end

  sitda_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_value (in_value),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_wdata  (q_wdata)
  );

  sitda_fifo #(
    .WIDTH(Q_W)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  sitda_back #(
    .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .min_width     (min_width_r),
    .q_stat        (q_stat),
    .q_rdata       (q_rdata),
    .q_pop         (q_pop),
    .out_strobe    (out_strobe),
    .out_character (out_character),
    .out_last      (out_last)
  );

  // a word taken in keeps the front end busy on the next cycle
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("front end not busy after taking a word");

  // a run of characters is contiguous until its last one
  a_run_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_last |=> out_strobe)
    else $error("gap inside a character run");

  // the emitter passes through its idle state between runs
  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last |=> !out_strobe)
    else $error("strobe right after last character");

  // nothing comes out right after reset
  a_quiet_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_strobe)
    else $error("strobe right after reset");

endmodule
